// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CHECK(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define AST_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define AST_CHECK(lbl, clk, rst, expr)
`define AST_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- hdl/skca_pkg.sv -----
package skca_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int SEQ_W           = 63;
   localparam int REQ_TDATA_W     = 128;
   localparam int RSP_TDATA_W     = 200;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [1:0] {
      ST_IN_ORDER = 2'd0,
      ST_GAP      = 2'd1,
      ST_REJECT   = 2'd2,
      ST_CLEAR    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_Y = 2'd0,   // y = value - comp
      OP_T = 2'd1,   // t = sum + y
      OP_D = 2'd2,   // d = t - sum
      OP_C = 2'd3    // comp = d - y
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_ISSUE = 2'd1,
      BK_WAIT  = 2'd2,
      BK_OUT   = 2'd3
   } back_state_type;

   // classified transaction handed from front to back
   typedef struct packed {
      status_type       status;
      logic             do_add;
      logic             crash;
      logic [63:0]      payload;
      logic [31:0]      count;
      logic [31:0]      gap;
      logic [SEQ_W-1:0] seq;
      logic             seq_valid;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ----- hdl/seq_checked_kahan_accumulator_top.sv -----
// Sequence-checked Kahan accumulator.
// req channel: one transaction per message or crash item. tuser = 1 marks a crash
//   item (clears sum, compensation, last sequence and count; gap total is kept).
// rsp channel: one transaction per request, in order, with the status and the
//   state after that request.
// The front end checks sequence numbers and updates the counters in the cycle a
// request is taken, then queues it (4 entries). The back end runs the Kahan
// update as four dependent additions through one 3-stage double adder.
// Each item is popped by the back end in its dispatch state. An accumulated
// message then runs four dependent additions, each an issue state and a wait
// through the 3 adder stages, before the output state loads the result register;
// a rejected or crash item goes from dispatch straight to the output state. A new
// item is taken from the queue only after the output state of the last one.
// Reset: synchronous; clears sum, compensation, counters, queue and result valid.
// A stalled rsp side holds the result register; the queue keeps taking requests
// until full, then req_tready drops.
module seq_checked_kahan_accumulator_top #(
   parameter int COUNT_WIDTH = skca_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [62:0] seq_num, [126:63] payload, [127] zero
   input  logic [skca_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [65:2] sum_bits, [97:66] accepted_count, [129:98] gap_total,
   // [192:130] latest_seq, [193] latest_seq_valid, [199:194] zero
   output logic [skca_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import skca_pkg::*;

   queue_stat_type qstat;
   entry_type      push_data, pop_data;
   logic           push, pop;

   skca_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   skca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (qstat)
   );

   skca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hdl/skca_fadd.sv -----
// three-stage IEEE double adder, round to nearest even
module skca_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic        sub,
   output logic        out_valid,
   output logic [63:0] result
);
   import skca_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_spec_ff, s1_spec_in;
   logic [63:0] s1_bits_ff, s1_bits_in;
   logic        s1_sign_ff, s1_sign_in;
   logic        s1_esub_ff, s1_esub_in;
   logic [10:0] s1_exp_ff, s1_exp_in;
   logic [56:0] s1_sum_ff, s1_sum_in;

   logic        s2_valid_ff;
   logic        s2_spec_ff;
   logic [63:0] s2_bits_ff;
   logic        s2_sign_ff, s2_sign_in;
   logic [11:0] s2_exp_ff, s2_exp_in;
   logic [55:0] s2_man_ff, s2_man_in;

   logic        s3_valid_ff;
   logic [63:0] s3_res_ff, s3_res_in;

   // stage 1: unpack, specials, swap, align, add
   logic        sa, sb, nan_a, nan_b, inf_a, inf_b, swap, s_big, s_small;
   logic [10:0] ea, eb, e_big, e_small, dexp;
   logic [52:0] ma, mb, m_big, m_small;
   logic [55:0] mx, my0, sh, al, smask;
   always_comb begin
      sa    = op_a[63];
      sb    = op_b[63] ^ sub;
      nan_a = (op_a[62:52] == 11'h7FF) && (op_a[51:0] != '0);
      nan_b = (op_b[62:52] == 11'h7FF) && (op_b[51:0] != '0);
      inf_a = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == '0);
      inf_b = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == '0);
      ea    = (op_a[62:52] == '0) ? 11'd1 : op_a[62:52];
      eb    = (op_b[62:52] == '0) ? 11'd1 : op_b[62:52];
      ma    = {op_a[62:52] != '0, op_a[51:0]};
      mb    = {op_b[62:52] != '0, op_b[51:0]};
      swap  = {ea, ma} < {eb, mb};
      e_big   = swap ? eb : ea;
      e_small = swap ? ea : eb;
      m_big   = swap ? mb : ma;
      m_small = swap ? ma : mb;
      s_big   = swap ? sb : sa;
      s_small = swap ? sa : sb;
      dexp  = e_big - e_small;
      mx    = {m_big, 3'b000};
      my0   = {m_small, 3'b000};
      sh    = my0 >> dexp;
      smask = (56'd1 << dexp) - 56'd1;
      if (dexp >= 11'd56) begin
         al = {55'd0, |my0};
      end else begin
         al = {sh[55:1], sh[0] | (|(my0 & smask))};
      end
      s1_esub_in = s_big != s_small;
      s1_sum_in  = s1_esub_in ? ({1'b0, mx} - {1'b0, al}) : ({1'b0, mx} + {1'b0, al});
      s1_sign_in = s_big;
      s1_exp_in  = e_big;
      s1_valid_in = in_valid;
      s1_spec_in = nan_a || nan_b || inf_a || inf_b;
      if (nan_a) begin
         s1_bits_in = op_a | 64'h0008_0000_0000_0000;
      end else if (nan_b) begin
         s1_bits_in = op_b | 64'h0008_0000_0000_0000;
      end else if (inf_a && inf_b && (sa != sb)) begin
         s1_bits_in = 64'hFFF8_0000_0000_0000;
      end else if (inf_a) begin
         s1_bits_in = op_a;
      end else begin
         s1_bits_in = {sb, 11'h7FF, 52'd0};
      end
   end

   // stage 2: leading zero count and normalize
   logic [5:0]  lz;
   logic [11:0] lim, shamt;
   always_comb begin
      lz = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (s1_sum_ff[i]) begin
            lz = 6'(55 - i);
         end
      end
      lim   = {1'b0, s1_exp_ff} - 12'd1;
      shamt = ({6'd0, lz} <= lim) ? {6'd0, lz} : lim;
      if (s1_sum_ff[56]) begin
         s2_man_in = {s1_sum_ff[56:2], s1_sum_ff[1] | s1_sum_ff[0]};
         s2_exp_in = {1'b0, s1_exp_ff} + 12'd1;
      end else begin
         s2_man_in = s1_sum_ff[55:0] << shamt;
         s2_exp_in = {1'b0, s1_exp_ff} - shamt;
      end
      // exact cancellation gives +0
      s2_sign_in = (s1_esub_ff && (s1_sum_ff == '0)) ? 1'b0 : s1_sign_ff;
   end

   // stage 3: round and pack
   logic        up;
   logic [53:0] rnd;
   logic [11:0] e2;
   always_comb begin
      up  = s2_man_ff[2] && (s2_man_ff[1] || s2_man_ff[0] || s2_man_ff[3]);
      rnd = {1'b0, s2_man_ff[55:3]} + {53'd0, up};
      e2  = s2_exp_ff + {11'd0, rnd[53]};
      if (s2_spec_ff) begin
         s3_res_in = s2_bits_ff;
      end else if (e2 >= 12'd2047) begin
         s3_res_in = {s2_sign_ff, 11'h7FF, 52'd0};
      end else if (rnd[53] || rnd[52]) begin
         s3_res_in = {s2_sign_ff, e2[10:0], rnd[51:0]};
      end else begin
         s3_res_in = {s2_sign_ff, 11'd0, rnd[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_spec_ff <= s1_spec_in;
      s1_bits_ff <= s1_bits_in;
      s1_sign_ff <= s1_sign_in;
      s1_esub_ff <= s1_esub_in;
      s1_exp_ff  <= s1_exp_in;
      s1_sum_ff  <= s1_sum_in;
      s2_spec_ff <= s1_spec_ff;
      s2_bits_ff <= s1_bits_ff;
      s2_sign_ff <= s2_sign_in;
      s2_exp_ff  <= s2_exp_in;
      s2_man_ff  <= s2_man_in;
      s3_res_ff  <= s3_res_in;
   end

   assign out_valid = s3_valid_ff;
   assign result    = s3_res_ff;

endmodule

// ----- hdl/skca_queue.sv -----
// small register queue between front and back
module skca_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  skca_pkg::entry_type  push_data,
   input  logic                 pop,
   output skca_pkg::entry_type  pop_data,
   output skca_pkg::queue_stat_type stat
);
   import skca_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ff];
   assign stat.full  = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign stat.empty = cnt_ff == '0;

endmodule

// ----- hdl/skca_front.sv -----
// sequence check and counters; classifies each transaction for the back end
module skca_front #(
   parameter int COUNT_WIDTH = skca_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [skca_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  skca_pkg::queue_stat_type            qstat,
   output logic                                push,
   output skca_pkg::entry_type                 push_data
);
   import skca_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [SEQ_W-1:0]       last_ff, last_in;
   logic                   seqv_ff, seqv_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] gap_ff, gap_in;

   logic [SEQ_W-1:0] seq, diff;
   logic [64:0]      gsum;
   logic [63:0]      cnt_ext, gap_ext;
   status_type       status;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready;
   assign seq        = req_tdata[SEQ_W-1:0];

   // classify and update sequence state
   always_comb begin
      last_in = last_ff;
      seqv_in = seqv_ff;
      cnt_in  = cnt_ff;
      gap_in  = gap_ff;
      diff    = seq - last_ff - SEQ_W'(1);
      gsum    = 65'(diff) + 65'(gap_ff);
      status  = ST_IN_ORDER;
      if (req_tuser) begin
         status  = ST_CLEAR;
         last_in = '0;
         seqv_in = 1'b0;
         cnt_in  = '0;
      end else if (seqv_ff && (seq <= last_ff)) begin
         status = ST_REJECT;
         gap_in = (gap_ff == CMAX) ? gap_ff : gap_ff + 1'b1;
      end else begin
         if (seqv_ff && (diff != '0)) begin
            status = ST_GAP;
            gap_in = (gsum > 65'(CMAX)) ? CMAX : gsum[COUNT_WIDTH-1:0];
         end
         last_in = seq;
         seqv_in = 1'b1;
         cnt_in  = (cnt_ff == CMAX) ? cnt_ff : cnt_ff + 1'b1;
      end
      cnt_ext = 64'(cnt_in);
      gap_ext = 64'(gap_in);
      push_data.status    = status;
      push_data.do_add    = (status == ST_IN_ORDER) || (status == ST_GAP);
      push_data.crash     = req_tuser;
      push_data.payload   = req_tdata[SEQ_W+63:SEQ_W];
      push_data.count     = cnt_ext[31:0];
      push_data.gap       = gap_ext[31:0];
      push_data.seq       = last_in;
      push_data.seq_valid = seqv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         seqv_ff <= 1'b0;
         cnt_ff  <= '0;
         gap_ff  <= '0;
      end else if (push) begin
         last_ff <= last_in;
         seqv_ff <= seqv_in;
         cnt_ff  <= cnt_in;
         gap_ff  <= gap_in;
      end
   end

endmodule

// ----- hdl/skca_back.sv -----
`include "assert_macros.svh"
// Kahan update through a shared adder, then the result register
module skca_back (
   input  logic                             clock,
   input  logic                             reset,
   input  skca_pkg::queue_stat_type         qstat,
   input  skca_pkg::entry_type              pop_data,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [skca_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import skca_pkg::*;

   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   entry_type      ent_ff, ent_in;
   logic [63:0]    sum_ff, sum_in, comp_ff, comp_in;
   logic [63:0]    y_ff, y_in, t_ff, t_in, d_ff, d_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        f_in_valid, f_sub, f_out_valid;
   logic [63:0] f_a, f_b, f_res;

   skca_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_in_valid),
      .op_a      (f_a),
      .op_b      (f_b),
      .sub       (f_sub),
      .out_valid (f_out_valid),
      .result    (f_res)
   );

   // operand selection per step
   always_comb begin
      case (op_ff)
         OP_Y: begin
            f_a = ent_ff.payload; f_b = comp_ff; f_sub = 1'b1;
         end
         OP_T: begin
            f_a = sum_ff; f_b = y_ff; f_sub = 1'b0;
         end
         OP_D: begin
            f_a = t_ff; f_b = sum_ff; f_sub = 1'b1;
         end
         OP_C: begin
            f_a = d_ff; f_b = y_ff; f_sub = 1'b1;
         end
         default: begin
            f_a = '0; f_b = '0; f_sub = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ent_in       = ent_ff;
      sum_in       = sum_ff;
      comp_in      = comp_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      pop          = 1'b0;
      f_in_valid   = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               ent_in = pop_data;
               op_in  = OP_Y;
               if (pop_data.do_add) begin
                  state_in = BK_ISSUE;
               end else begin
                  if (pop_data.crash) begin
                     sum_in  = '0;
                     comp_in = '0;
                  end
                  state_in = BK_OUT;
               end
            end
         end
         BK_ISSUE: begin
            f_in_valid = 1'b1;
            state_in   = BK_WAIT;
         end
         BK_WAIT: begin
            if (f_out_valid) begin
               case (op_ff)
                  OP_Y: y_in = f_res;
                  OP_T: t_in = f_res;
                  OP_D: d_in = f_res;
                  OP_C: begin
                     comp_in = f_res;
                     sum_in  = t_ff;
                  end
                  default: ;
               endcase
               if (op_ff == OP_C) begin
                  state_in = BK_OUT;
               end else begin
                  op_in    = op_type'(op_ff + 2'd1);
                  state_in = BK_ISSUE;
               end
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, ent_ff.seq_valid, ent_ff.seq, ent_ff.gap,
                               ent_ff.count, sum_ff, ent_ff.status};
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         op_ff        <= OP_Y;
         sum_ff       <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sum_ff       <= sum_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff      <= ent_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `AST_CHECK(fadd_res_in_wait, clock, reset, !f_out_valid || (state_ff == BK_WAIT))
   `AST_NEXT(issue_then_wait, clock, reset, state_ff == BK_ISSUE, state_ff == BK_WAIT)
   `AST_CHECK(pop_only_idle, clock, reset, !pop || ((state_ff == BK_IDLE) && !qstat.empty))
   `AST_NEXT(out_loads_rsp, clock, reset, (state_ff == BK_OUT) && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && (state_ff == BK_IDLE))

endmodule
